/* rtl/quaternion_to_axis_angle_macros.svh */
// Assertion macros shared by the quaternion to axis-angle RTL
`ifndef QUATERNION_TO_AXIS_ANGLE_MACROS_SVH
`define QUATERNION_TO_AXIS_ANGLE_MACROS_SVH
`ifndef SYNTHESIS
`define QAA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qaa assertion failed");
`define QAA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("qaa reset assertion failed");
`else
`define QAA_ASSERT(lbl, prop)
`define QAA_ASSERT_RST(lbl, prop)
`endif
`endif

/* rtl/qaa_pkg.sv */
// Shared constants and helper functions for the quaternion to axis-angle block
package qaa_pkg;

  localparam int unsigned CompBits      = 16;
  localparam int unsigned CordicDefault = 16;
  localparam int unsigned SqW           = 32;  // squared component, sum of squares
  localparam int unsigned RootW         = 32;  // root of sum of squares << 32
  localparam int unsigned WRootW        = 16;  // root of 1 - w*w
  localparam int unsigned DivNW         = 49;  // dividend / partial remainder
  localparam int unsigned DivDW         = 33;  // divisor 2*r
  localparam int unsigned DivQW         = 17;  // quotient bits
  localparam int unsigned AngW          = 34;  // CORDIC datapath, Q30

  localparam logic signed [AngW-1:0] PiHalfQ30 = 34'sd1686629713;
  localparam logic signed [AngW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic [SqW-1:0]         OneSqQ30  = 32'h4000_0000;

  localparam logic [CompBits-1:0] AxisPosSat = 16'h7fff;
  localparam logic [CompBits-1:0] AxisNegSat = 16'h8000;

  // atan(2^-idx) in Q30, rounded down
  function automatic logic signed [AngW-1:0] atan_q30(input int unsigned idx);
    logic signed [AngW-1:0] v;
    case (idx)
      0: v = 34'sd843314856;
      1: v = 34'sd497837829;
      2: v = 34'sd263043836;
      3: v = 34'sd133525158;
      4: v = 34'sd67021686;
      5: v = 34'sd33543515;
      6: v = 34'sd16775850;
      7: v = 34'sd8388437;
      8: v = 34'sd4194282;
      9: v = 34'sd2097149;
      default: v = (idx <= 30) ? ((34'sd1 <<< (30 - idx)) - 34'sd1) : '0;
    endcase
    return v;
  endfunction

  function automatic logic [CompBits-1:0] mag16(input logic signed [CompBits-1:0] v);
    return v[CompBits-1] ? CompBits'(-v) : v;
  endfunction

  // saturate a rounded quotient to signed Q1.15
  function automatic logic [CompBits-1:0] sat_axis(input logic [DivQW-1:0] q,
                                                   input logic neg);
    logic [CompBits-1:0] r;
    if (neg) begin
      r = (q > 17'd32768) ? AxisNegSat : CompBits'(-q);
    end else begin
      r = (q > 17'd32767) ? AxisPosSat : q[CompBits-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/qaa_sqrt_cell.sv */
// One digit step of a restoring integer square root
module qaa_sqrt_cell #(
  parameter int unsigned RW = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW+1:0]   rem_o,
  output logic [RW-1:0]   root_o,
  output logic [2*RW-1:0] rad_o
);

  logic [RW+3:0] cand, trial, diff;
  logic          ge;
  logic [RW+1:0]   rem_d;
  logic [RW-1:0]   root_d;
  logic [2*RW-1:0] rad_d;
  logic [RW+1:0]   rem_q;
  logic [RW-1:0]   root_q;
  logic [2*RW-1:0] rad_q;

  always_comb begin
    cand   = {rem_i, rad_i[2*RW-1 -: 2]};
    trial  = {2'b00, root_i, 2'b01};
    ge     = (cand >= trial);
    diff   = cand - trial;
    rem_d  = ge ? diff[RW+1:0] : cand[RW+1:0];
    root_d = {root_i[RW-2:0], ge};
    rad_d  = {rad_i[2*RW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;

endmodule

/* rtl/qaa_div_cell.sv */
// One quotient bit of a restoring divider
module qaa_div_cell #(
  parameter int unsigned NW = 49,
  parameter int unsigned DW = 33,
  parameter int unsigned QW = 17,
  parameter int unsigned SH = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] quo_i,
  output logic [NW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QW-1:0] quo_o
);

  logic [NW-1:0] dsh;
  logic          ge;
  logic [NW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [QW-1:0] quo_q;

  always_comb begin
    dsh = NW'(den_i) << SH;
    ge  = (rem_i >= dsh);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= ge ? (rem_i - dsh) : rem_i;
      den_q <= den_i;
      quo_q <= {quo_i[QW-2:0], ge};
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;

endmodule

/* rtl/qaa_cordic_cell.sv */
// One vectoring step of the arccos CORDIC
module qaa_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [qaa_pkg::AngW-1:0]     cx_i,
  input  logic signed [qaa_pkg::AngW-1:0]     cy_i,
  input  logic signed [qaa_pkg::AngW-1:0]     z_i,
  output logic signed [qaa_pkg::AngW-1:0]     cx_o,
  output logic signed [qaa_pkg::AngW-1:0]     cy_o,
  output logic signed [qaa_pkg::AngW-1:0]     z_o
);

  logic signed [qaa_pkg::AngW-1:0] dx, dy, ang;
  logic signed [qaa_pkg::AngW-1:0] cx_q, cy_q, z_q;

  always_comb begin
    dx  = cy_i >>> IDX;
    dy  = cx_i >>> IDX;
    ang = qaa_pkg::atan_q30(IDX);
  end

  // rotate toward the x axis, steered by the sign of y
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!cy_i[qaa_pkg::AngW-1]) begin
        cx_q <= cx_i + dx;
        cy_q <= cy_i - dy;
        z_q  <= z_i + ang;
      end else begin
        cx_q <= cx_i - dx;
        cy_q <= cy_i + dy;
        z_q  <= z_i - ang;
      end
    end
  end

  assign cx_o = cx_q;
  assign cy_o = cy_q;
  assign z_o  = z_q;

endmodule

/* rtl/qaa_delay.sv */
// Enabled shift line that keeps side data aligned with the datapath cells
module qaa_delay #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

/* rtl/quaternion_to_axis_angle.sv */
// Throughput: one request per cycle; the chain of square root, divider and CORDIC
// cells advances as a whole and holds only while the output register is full and not taken.
// Pipeline depth is set by the 32-cell square root plus the 17-cell divider of the axis path.
// Reset clears the valid bits of the pipeline; the payload registers are not reset.
module quaternion_to_axis_angle #(
  parameter int unsigned CORDIC_STAGES = qaa_pkg::CordicDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] quat_x_i,
  input  logic [15:0] quat_y_i,
  input  logic [15:0] quat_z_i,
  input  logic [15:0] quat_w_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] axis_x_o,
  output logic [15:0] axis_y_o,
  output logic [15:0] axis_z_o,
  output logic [15:0] angle_rad_o,
  output logic        degenerate_o,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i
);

  `include "quaternion_to_axis_angle_macros.svh"

  localparam int unsigned CB       = qaa_pkg::CompBits;
  localparam int unsigned SqCells  = qaa_pkg::RootW;
  localparam int unsigned DivCells = qaa_pkg::DivQW;
  localparam int unsigned WCells   = qaa_pkg::WRootW;
  localparam int unsigned AW       = qaa_pkg::AngW;
  localparam int unsigned AngPad   = SqCells + DivCells - WCells - CORDIC_STAGES;
  localparam int unsigned NS       = 3 + SqCells + DivCells + 1;

  logic          en;
  logic [NS-1:0] vld_q;
  logic [14:0]   sine_limit_q;

  assign en         = !vld_q[NS-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      sine_limit_q <= 15'd16;
    end else begin
      if (en) begin
        vld_q <= {vld_q[NS-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        sine_limit_q <= cfg_wdata_i;
      end
    end
  end

  // stage 1: capture the request
  logic signed [CB-1:0] x1_q, y1_q, z1_q, w1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= quat_x_i;
      y1_q <= quat_y_i;
      z1_q <= quat_z_i;
      w1_q <= quat_w_i;
    end
  end

  // stage 2: squares
  logic [CB-1:0]              ax1, ay1, az1, aw1;
  logic [qaa_pkg::SqW-1:0]    sqx2_q, sqy2_q, sqz2_q, sqw2_q;
  logic [CB-1:0]              ax2_q, ay2_q, az2_q;
  logic [2:0]                 sgn2_q;
  logic signed [CB-1:0]       w2_q;

  assign ax1 = qaa_pkg::mag16(x1_q);
  assign ay1 = qaa_pkg::mag16(y1_q);
  assign az1 = qaa_pkg::mag16(z1_q);
  assign aw1 = qaa_pkg::mag16(w1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx2_q <= ax1 * ax1;
      sqy2_q <= ay1 * ay1;
      sqz2_q <= az1 * az1;
      sqw2_q <= aw1 * aw1;
      ax2_q  <= ax1;
      ay2_q  <= ay1;
      az2_q  <= az1;
      sgn2_q <= {z1_q[CB-1], y1_q[CB-1], x1_q[CB-1]};
      w2_q   <= w1_q;
    end
  end

  // stage 3: sum of squares and 1 - w*w
  logic [qaa_pkg::SqW-1:0] sumsq3_q, radw3_q;
  logic [CB-1:0]           ax3_q, ay3_q, az3_q;
  logic [2:0]              sgn3_q;
  logic                    deg3_q;
  logic signed [CB-1:0]    w3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sumsq3_q <= sqx2_q + sqy2_q + sqz2_q;
      radw3_q  <= qaa_pkg::OneSqQ30 - sqw2_q;
      ax3_q    <= ax2_q;
      ay3_q    <= ay2_q;
      az3_q    <= az2_q;
      sgn3_q   <= sgn2_q;
      deg3_q   <= ~|{ax2_q, ay2_q, az2_q};
      w3_q     <= w2_q;
    end
  end

  // axis path: square root of sumsq << 32, one root bit per cell
  logic [SqCells+1:0]   sq_rem  [SqCells+1];
  logic [SqCells-1:0]   sq_root [SqCells+1];
  logic [2*SqCells-1:0] sq_rad  [SqCells+1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = {sumsq3_q, 32'h0000_0000};

  for (genvar k = 0; k < SqCells; k++) begin : g_sq
    qaa_sqrt_cell #(.RW(SqCells)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_i  (sq_rad[k]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .rad_o  (sq_rad[k+1])
    );
  end

  logic [3*CB-1:0] mags_d;
  qaa_delay #(.W(3*CB), .DEPTH(SqCells)) u_mag_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({az3_q, ay3_q, ax3_q}),
    .q_o   (mags_d)
  );

  logic [3:0] side_d;
  qaa_delay #(.W(4), .DEPTH(SqCells + DivCells)) u_side_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({deg3_q, sgn3_q}),
    .q_o   (side_d)
  );

  // axis path: round(|c| * 2^32 / (2r)), one quotient bit per cell and lane
  logic [qaa_pkg::DivNW-1:0] dv_rem [3][DivCells+1];
  logic [qaa_pkg::DivDW-1:0] dv_den [3][DivCells+1];
  logic [DivCells-1:0]       dv_quo [3][DivCells+1];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    assign dv_rem[c][0] = {1'b0, mags_d[c*CB +: CB], 32'h0000_0000}
                          + qaa_pkg::DivNW'(sq_root[SqCells]);
    assign dv_den[c][0] = {sq_root[SqCells], 1'b0};
    assign dv_quo[c][0] = '0;
    for (genvar k = 0; k < DivCells; k++) begin : g_div
      qaa_div_cell #(
        .NW (qaa_pkg::DivNW),
        .DW (qaa_pkg::DivDW),
        .QW (DivCells),
        .SH (DivCells - 1 - k)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .rem_i (dv_rem[c][k]),
        .den_i (dv_den[c][k]),
        .quo_i (dv_quo[c][k]),
        .rem_o (dv_rem[c][k+1]),
        .den_o (dv_den[c][k+1]),
        .quo_o (dv_quo[c][k+1])
      );
    end
  end

  // angle path: sine = sqrt(1 - w*w) in Q1.15
  logic [WCells+1:0]   ws_rem  [WCells+1];
  logic [WCells-1:0]   ws_root [WCells+1];
  logic [2*WCells-1:0] ws_rad  [WCells+1];

  assign ws_rem[0]  = '0;
  assign ws_root[0] = '0;
  assign ws_rad[0]  = radw3_q;

  for (genvar k = 0; k < WCells; k++) begin : g_ws
    qaa_sqrt_cell #(.RW(WCells)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (ws_rem[k]),
      .root_i (ws_root[k]),
      .rad_i  (ws_rad[k]),
      .rem_o  (ws_rem[k+1]),
      .root_o (ws_root[k+1]),
      .rad_o  (ws_rad[k+1])
    );
  end

  logic [CB-1:0] w_d;
  qaa_delay #(.W(CB), .DEPTH(WCells)) u_w_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (w3_q),
    .q_o   (w_d)
  );

  // fold a negative w into the right half plane before vectoring
  logic signed [AW-1:0] cxs, cys, cx0, cy0, z0;
  logic signed [AW-1:0] cd_cx [CORDIC_STAGES+1];
  logic signed [AW-1:0] cd_cy [CORDIC_STAGES+1];
  logic signed [AW-1:0] cd_z  [CORDIC_STAGES+1];

  always_comb begin
    cxs = AW'($signed(w_d)) <<< 15;
    cys = $signed({{(AW-WCells){1'b0}}, ws_root[WCells]}) <<< 15;
    if (w_d[CB-1]) begin
      cx0 = cys;
      cy0 = -cxs;
      z0  = qaa_pkg::PiHalfQ30;
    end else begin
      cx0 = cxs;
      cy0 = cys;
      z0  = '0;
    end
  end

  assign cd_cx[0] = cx0;
  assign cd_cy[0] = cy0;
  assign cd_z[0]  = z0;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    qaa_cordic_cell #(.IDX(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .cx_i  (cd_cx[k]),
      .cy_i  (cd_cy[k]),
      .z_i   (cd_z[k]),
      .cx_o  (cd_cx[k+1]),
      .cy_o  (cd_cy[k+1]),
      .z_o   (cd_z[k+1])
    );
  end

  logic [AW-1:0] z_d;
  qaa_delay #(.W(AW), .DEPTH(AngPad)) u_z_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (cd_z[CORDIC_STAGES]),
    .q_o   (z_d)
  );

  // output stage: clamp and round the angle, saturate the axis; a degenerate request gets the default result
  logic signed [AW-1:0] zc;
  logic [AW-1:0]        zr;
  logic [CB-1:0]        ang, ox, oy, oz;

  always_comb begin
    zc = $signed(z_d);
    if (zc < 0) begin
      zc = '0;
    end else if (zc > qaa_pkg::PiQ30) begin
      zc = qaa_pkg::PiQ30;
    end
    zr  = zc + AW'(32768);
    ang = zr[31:16];
    ox  = qaa_pkg::sat_axis(dv_quo[0][DivCells], side_d[0]);
    oy  = qaa_pkg::sat_axis(dv_quo[1][DivCells], side_d[1]);
    oz  = qaa_pkg::sat_axis(dv_quo[2][DivCells], side_d[2]);
  end

  logic [CB-1:0] axis_x_q, axis_y_q, axis_z_q, angle_q;
  logic          deg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (side_d[3]) begin
        axis_x_q <= '0;
        axis_y_q <= '0;
        axis_z_q <= qaa_pkg::AxisPosSat;
        angle_q  <= '0;
      end else begin
        axis_x_q <= ox;
        axis_y_q <= oy;
        axis_z_q <= oz;
        angle_q  <= ang;
      end
      deg_q <= side_d[3];
    end
  end

  assign out_valid_o  = vld_q[NS-1];
  assign axis_x_o     = axis_x_q;
  assign axis_y_o     = axis_y_q;
  assign axis_z_o     = axis_z_q;
  assign angle_rad_o  = angle_q;
  assign degenerate_o = deg_q;

  logic deg_ok;
  assign deg_ok = (axis_x_o == '0) && (axis_y_o == '0) &&
                  (axis_z_o == qaa_pkg::AxisPosSat) && (angle_rad_o == '0);

  `QAA_ASSERT(a_deg_default, out_valid_o && degenerate_o |-> deg_ok)
  `QAA_ASSERT(a_angle_range, out_valid_o |-> angle_rad_o <= 16'd51472)
  `QAA_ASSERT(a_accept_enters, in_valid_i && in_ready_o |=> vld_q[0])
  `QAA_ASSERT(a_cfg_write, cfg_we_i |=> sine_limit_q == $past(cfg_wdata_i))
  `QAA_ASSERT_RST(a_reset_empty, !rst_ni |-> vld_q == '0)

endmodule

/* test/tb_quaternion_to_axis_angle.sv */
// Testbench for the quaternion to axis-angle converter with a self-checking scoreboard
`timescale 1ns / 100ps

class axis_angle_board;
  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [15:0] ang;
    logic        degen;
  } axis_angle_t;

  axis_angle_t pending[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  static function longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  static function logic [15:0] unit_comp(longint c, longint unsigned r);
    longint unsigned q, m;
    m = (c < 0) ? -c : c;
    q = ((m << 32) + r) / (r << 1);
    if (c < 0) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
    return (q > 32767) ? 16'h7fff : 16'(q);
  endfunction

  static function logic [15:0] twice_acos(logic signed [15:0] w);
    longint unsigned wm;
    longint s, cx, cy, z, t, dx, dy, at;
    wm = (w < 0) ? -longint'(w) : longint'(w);
    s = int_sqrt(64'd1073741824 - wm * wm);
    cx = longint'(w) <<< 15;
    cy = s <<< 15;
    z = 0;
    if (cx < 0) begin
      t = cx;
      cx = cy;
      cy = -t;
      z = 1686629713;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(cy, i);
      dy = floor_shift(cx, i);
      at = qaa_pkg::atan_q30(i);
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += at;
      end else begin
        cx -= dx; cy += dy; z -= at;
      end
    end
    if (z < 0) z = 0;
    if (z > 64'sd3373259426) z = 64'sd3373259426;
    return 16'((z + (64'd1 << 15)) >> 16);
  endfunction

  function void note_request(logic signed [15:0] x, y, z, w);
    axis_angle_t e;
    longint unsigned sq, r;
    sq = longint'(x) * x + longint'(y) * y + longint'(z) * z;
    if (sq == 0) begin
      e = '{16'd0, 16'd0, 16'h7fff, 16'd0, 1'b1};
    end else begin
      r = int_sqrt(sq << 32);
      e.ax = unit_comp(x, r);
      e.ay = unit_comp(y, r);
      e.az = unit_comp(z, r);
      e.ang = twice_acos(w);
      e.degen = 1'b0;
    end
    pending.push_back(e);
  endfunction

  function void check_result(axis_angle_t got);
    axis_angle_t e;
    if (pending.size() == 0) begin
      $display("%0t unexpected result %h", $time, got);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.ax !== e.ax) begin
      $display("%0t axis_x exp %h got %h", $time, e.ax, got.ax); errors++;
    end
    if (got.ay !== e.ay) begin
      $display("%0t axis_y exp %h got %h", $time, e.ay, got.ay); errors++;
    end
    if (got.az !== e.az) begin
      $display("%0t axis_z exp %h got %h", $time, e.az, got.az); errors++;
    end
    if (got.ang !== e.ang) begin
      $display("%0t angle exp %h got %h", $time, e.ang, got.ang); errors++;
    end
    if (got.degen !== e.degen) begin
      $display("%0t degenerate exp %b got %b", $time, e.degen, got.degen); errors++;
    end
  endfunction
endclass

module tb_quaternion_to_axis_angle;
  localparam int unsigned WatchdogLimit = 20000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [15:0] quat_x_i, quat_y_i, quat_z_i, quat_w_i;
  logic [15:0] axis_x_o, axis_y_o, axis_z_o, angle_rad_o;
  logic        degenerate_o, cfg_we_i;
  logic [14:0] cfg_wdata_i;

  int unsigned send_idle_pct, recv_idle_pct, stuck_cycles;
  axis_angle_board board;

  quaternion_to_axis_angle i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, check on every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result('{axis_x_o, axis_y_o, axis_z_o, angle_rad_o, degenerate_o});
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid stays high after an accepted request until the next call drops or reloads it
  task automatic send_quat(logic [15:0] x, y, z, w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    quat_x_i <= x; quat_y_i <= y; quat_z_i <= z; quat_w_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(x, y, z, w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [14:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // roughly unit quaternion: pick w, spread the rest over the vector part
  task automatic send_unit();
    logic signed [15:0] w, x, y, z;
    longint unsigned rest, a, b;
    w = 16'($urandom);
    rest = 64'd1073741824 - longint'(w) * w;
    a = $urandom_range(1000);
    b = $urandom_range(1000 - a);
    x = 16'(board.int_sqrt(rest * a / 1000));
    y = 16'(board.int_sqrt(rest * b / 1000));
    z = 16'(board.int_sqrt(rest * (1000 - a - b) / 1000));
    if ($urandom_range(1)) x = -x;
    if ($urandom_range(1)) y = -y;
    if ($urandom_range(1)) z = -z;
    send_quat(x, y, z, w);
  endtask

  initial begin
    logic [14:0] limits[4];
    board = new();
    limits = '{15'd0, 15'h7fff, 15'd16, 15'd300};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    quat_x_i = '0; quat_y_i = '0; quat_z_i = '0; quat_w_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stuck_cycles = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7fff);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h1234);
    send_quat(16'h0000, 16'h0000, 16'h0001, 16'h8000);
    send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h8000, 16'h0000, 16'hc000);
    send_quat(16'h0000, 16'h0000, 16'h8000, 16'h4000);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'hffff, 16'h0001, 16'hffff, 16'h8001);
    send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0001);
    send_quat(16'h0005, 16'hfffb, 16'h0003, 16'hffff);
    send_quat(16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_limit(limits[phase]);
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 31 : 0;
      for (int n = 0; n < 275; n++) begin
        if ($urandom_range(3) != 0) send_unit();
        else send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        // hold off until the pipeline is empty once per phase
        if (n == 137) begin
          in_valid_i <= 1'b0;
          while (board.pending.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl
rtl/qaa_pkg.sv
rtl/qaa_sqrt_cell.sv
rtl/qaa_div_cell.sv
rtl/qaa_cordic_cell.sv
rtl/qaa_delay.sv
rtl/quaternion_to_axis_angle.sv
test/tb_quaternion_to_axis_angle.sv
